@@ hdl/assert_macros.svh @@
// assertion macros used by the top level of the frame decoder
// no dependencies; expects clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define OBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define OBD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/obd_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the diagnostic frame decoder
// no dependencies
package obd_pkg;

  localparam int unsigned ID_W    = 11;
  localparam int unsigned GAIN_W  = 20;
  localparam int unsigned ANGLE_W = 36;
  localparam int unsigned VAL12_W = 12;
  localparam int unsigned WHEEL_W = 11;
  localparam int unsigned CIDX_W  = 3;

  // register indexes of the configuration channel
  localparam logic [CIDX_W-1:0] REG_STEER_ID = 3'd0;
  localparam logic [CIDX_W-1:0] REG_SPEED_ID = 3'd1;
  localparam logic [CIDX_W-1:0] REG_BRAKE_ID = 3'd2;
  localparam logic [CIDX_W-1:0] REG_GAIN     = 3'd3;

  // reset values
  localparam logic [ID_W-1:0]   STEER_ID_RST = 11'd688;
  localparam logic [ID_W-1:0]   SPEED_ID_RST = 11'd1200;
  localparam logic [ID_W-1:0]   BRAKE_ID_RST = 11'd544;
  localparam logic [GAIN_W-1:0] GAIN_RST     = 20'd29281;

  typedef enum logic [1:0] {
    KIND_STEER = 2'd0,
    KIND_SPEED = 2'd1,
    KIND_BRAKE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [ID_W-1:0]   steer_id;
    logic [ID_W-1:0]   speed_id;
    logic [ID_W-1:0]   brake_id;
    logic [GAIN_W-1:0] gain;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]   frame_id;
    logic [7:0][7:0]   data;
  } frame_t;

  typedef struct packed {
    kind_t                      kind;
    logic signed [ANGLE_W-1:0]  steering_angle;
    logic [VAL12_W-1:0]         speed_sum;
    logic [VAL12_W-1:0]         brake_level;
  } result_t;

endpackage

@@ hdl/obd_if.sv @@
`timescale 1ns / 1ps
// channel interfaces of the frame decoder: frames in, results out, register writes
// depends on obd_pkg
interface obd_frame_if;
  import obd_pkg::*;
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] frame_id;
  logic [7:0]      byte0;
  logic [7:0]      byte1;
  logic [7:0]      byte2;
  logic [7:0]      byte3;
  logic [7:0]      byte4;
  logic [7:0]      byte5;
  logic [7:0]      byte6;
  logic [7:0]      byte7;
  modport source (output valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5,
                  byte6, byte7, input ready);
  modport sink   (input valid, frame_id, byte0, byte1, byte2, byte3, byte4, byte5,
                  byte6, byte7, output ready);
endinterface

interface obd_result_if;
  import obd_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                kind;
  logic signed [ANGLE_W-1:0] steering_angle;
  logic [VAL12_W-1:0]        speed_sum;
  logic [VAL12_W-1:0]        brake_level;
  modport source (output valid, kind, steering_angle, speed_sum, brake_level,
                  input ready);
  modport sink   (input valid, kind, steering_angle, speed_sum, brake_level,
                  output ready);
endinterface

interface obd_cfg_if;
  import obd_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  logic [GAIN_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/obd_cfg_regs.sv @@
`timescale 1ns / 1ps
// configuration registers: frame identifiers and steering gain
// depends on obd_pkg and obd_if
module obd_cfg_regs (
  input  logic         clk,
  input  logic         rst,
  obd_cfg_if.sink      cfg,
  output obd_pkg::cfg_t regs
);
  import obd_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.steer_id <= STEER_ID_RST;
      regs.speed_id <= SPEED_ID_RST;
      regs.brake_id <= BRAKE_ID_RST;
      regs.gain     <= GAIN_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_STEER_ID: regs.steer_id <= cfg.data[ID_W-1:0];
        REG_SPEED_ID: regs.speed_id <= cfg.data[ID_W-1:0];
        REG_BRAKE_ID: regs.brake_id <= cfg.data[ID_W-1:0];
        REG_GAIN:     regs.gain     <= cfg.data;
        default: begin
          // unknown index, write dropped
        end
      endcase
    end
  end

endmodule

@@ hdl/obd_decode.sv @@
`timescale 1ns / 1ps
// identifier match and value decode of one frame, purely combinational
// depends on obd_pkg
module obd_decode (
  input  obd_pkg::frame_t  frame,
  input  obd_pkg::cfg_t    regs,
  output logic             hit,
  output obd_pkg::result_t res
);
  import obd_pkg::*;

  logic signed [15:0]          raw_angle;
  logic signed [GAIN_W:0]      gain_s;
  logic signed [GAIN_W+16:0]   product;
  logic [WHEEL_W-1:0]          w0, w1, w2, w3;
  logic [WHEEL_W-1:0]          lo01, hi01, lo23, hi23, mid_a, mid_b;
  logic [VAL12_W-1:0]          mid_sum;

  // raw*5/16 in tenths
  function automatic logic [WHEEL_W-1:0] tenths(input logic [7:0] lo, input logic [7:0] hi);
    logic [VAL12_W-1:0] raw;
    logic [14:0]        x5;
    raw = {hi[3:0], lo};
    x5  = {3'b000, raw} + {1'b0, raw, 2'b00};
    return x5[14:4];
  endfunction

  // little-endian angle in byte0 (low) and byte1 (high)
  assign raw_angle = signed'({frame.data[1], frame.data[0]});
  assign gain_s    = signed'({1'b0, regs.gain});
  assign product   = raw_angle * gain_s;

  assign w0 = tenths(frame.data[0], frame.data[1]);
  assign w1 = tenths(frame.data[2], frame.data[3]);
  assign w2 = tenths(frame.data[4], frame.data[5]);
  assign w3 = tenths(frame.data[6], frame.data[7]);

  // middle two of four: larger of the pair minima and smaller of the pair maxima
  assign lo01  = (w0 < w1) ? w0 : w1;
  assign hi01  = (w0 < w1) ? w1 : w0;
  assign lo23  = (w2 < w3) ? w2 : w3;
  assign hi23  = (w2 < w3) ? w3 : w2;
  assign mid_a = (lo01 > lo23) ? lo01 : lo23;
  assign mid_b = (hi01 < hi23) ? hi01 : hi23;
  assign mid_sum = {1'b0, mid_a} + {1'b0, mid_b};

  always_comb begin
    hit = 1'b1;
    res = '0;
    if (frame.frame_id == regs.steer_id) begin
      res.kind           = KIND_STEER;
      res.steering_angle = product[ANGLE_W-1:0];
    end else if (frame.frame_id == regs.speed_id) begin
      res.kind      = KIND_SPEED;
      res.speed_sum = mid_sum;
    end else if (frame.frame_id == regs.brake_id) begin
      res.kind        = KIND_BRAKE;
      res.brake_level = {frame.data[5][3:0], frame.data[4]};
    end else begin
      hit = 1'b0;
    end
  end

endmodule

@@ hdl/obd_frame_decoder.sv @@
`timescale 1ns / 1ps
// top level of the diagnostic frame decoder: input register, decode, result register
// depends on obd_pkg, obd_if, obd_cfg_regs, obd_decode and assert_macros.svh
//
// channel   side   transaction carries
// -------   ----   ---------------------------------------------------
// frame     sink   frame_id, byte0 .. byte7
// result    source kind, steering_angle, speed_sum, brake_level
// cfg       sink   index, data (register write, always ready)
//
// an accepted frame is held in the input register, decoded, then held in the result register until taken
// one frame per cycle sustained while result.ready stays high
// the rate is set by the combinational decode between the two registers (16 x 21 multiply)
// synchronous reset clears both valid flags and loads register defaults
// a stalled result holds the input stage; unmatched frames leave without a result
`include "assert_macros.svh"

module obd_frame_decoder (
  input  logic          clk,
  input  logic          rst,
  obd_frame_if.sink     frame,
  obd_result_if.source  result,
  obd_cfg_if.sink       cfg
);
  import obd_pkg::*;

  cfg_t    regs;
  frame_t  s1_item;
  logic    s1_valid;
  logic    hit;
  result_t dec_res;
  result_t out_item;
  logic    out_valid;
  logic    out_free;
  logic    s1_go;

  obd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // result slot can take a new value this cycle
  assign out_free    = !out_valid || result.ready;
  assign s1_go       = s1_valid && out_free;
  assign frame.ready = !s1_valid || out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (frame.ready) begin
      s1_valid <= frame.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      s1_item.frame_id <= frame.frame_id;
      s1_item.data     <= {frame.byte7, frame.byte6, frame.byte5, frame.byte4,
                           frame.byte3, frame.byte2, frame.byte1, frame.byte0};
    end
  end

  obd_decode u_decode (
    .frame (s1_item),
    .regs  (regs),
    .hit   (hit),
    .res   (dec_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid && hit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && hit) begin
      out_item <= dec_res;
    end
  end

  assign result.valid          = out_valid;
  assign result.kind           = out_item.kind;
  assign result.steering_angle = out_item.steering_angle;
  assign result.speed_sum      = out_item.speed_sum;
  assign result.brake_level    = out_item.brake_level;

  // checks
  `OBD_ASSERT_ALWAYS(a_reset_clears, rst |=> (!s1_valid && !out_valid), "valid after reset")
  `OBD_ASSERT(a_hit_lands, (s1_go && hit) |=> out_valid, "matched frame lost")
  `OBD_ASSERT(a_stall_holds, (s1_valid && !out_free) |=> (s1_valid && $stable(s1_item)), "input stage lost under stall")
  `OBD_ASSERT(a_steer_clean, (out_valid && out_item.kind == KIND_STEER) |-> (out_item.speed_sum == '0 && out_item.brake_level == '0), "stray value beside steering result")

endmodule
